FILE: hw/rtl/assert_macros.svh
// Shared assertion shorthands; clock is clk, reset is rst_n (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/kmpt_pkg.sv
package kmpt_pkg;

    localparam int SLOTS_DEFAULT = 64;
    localparam int KEY_W         = 64;
    localparam int ENTITY_W      = 32;
    localparam int SLOT_OUT_W    = 6;
    localparam int MAX_REPORTS   = 64;
    localparam int HIT_W         = $clog2(MAX_REPORTS + 1);

    localparam logic [1:0] MODE_LOOKUP  = 2'd0;
    localparam logic [1:0] MODE_GAINED  = 2'd1;
    localparam logic [1:0] MODE_REMOVED = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_KEY = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_FLUSH,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MUL_RECIP,
        PH_MUL_DIV,
        PH_REDUCE
    } mod_phase_t;

    typedef struct packed {
        logic empty;
        logic equal;
        logic in_mask;
        logic in_prev;
    } match_t;

endpackage

FILE: hw/rtl/kmpt_key_mem.sv
module kmpt_key_mem
    import kmpt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT,
    localparam int SLOT_W = $clog2(SLOTS)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [SLOT_W-1:0] waddr,
    input  logic [KEY_W-1:0]  wdata,
    input  logic              re,
    input  logic [SLOT_W-1:0] raddr,
    output logic [KEY_W-1:0]  rdata
);

    logic [KEY_W-1:0] mem [SLOTS];
    logic [KEY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/kmpt_mod_unit.sv
module kmpt_mod_unit
    import kmpt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT,
    localparam int SLOT_W = $clog2(SLOTS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [KEY_W-1:0]  key,
    output logic              done,
    output logic [SLOT_W-1:0] rem
);

    // Fold 16 key bits a pass, top first: x = rem * 2^16 + chunk. The quotient
    // estimate floor(x * RECIP / 2^X_W) is at most one short, so one conditional
    // subtract finishes the pass.
    localparam int CHUNK_W = 16;
    localparam int X_W     = SLOT_W + CHUNK_W;
    localparam int RECIP_W = CHUNK_W + 1;
    localparam int PROD_W  = X_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'((longint'(1) << X_W) / longint'(SLOTS));
    localparam logic [RECIP_W-1:0] DIVISOR    = RECIP_W'(SLOTS);
    localparam logic [SLOT_W:0]    DIV_NARROW = (SLOT_W + 1)'(SLOTS);
    localparam logic [1:0]         LAST_CHUNK = 2'(KEY_W / CHUNK_W - 1);

    mod_phase_t            phase_reg, phase_next;
    logic [1:0]            chunk_cnt_reg, chunk_cnt_next;
    logic                  done_reg, done_next;
    logic [KEY_W-1:0]      shift_reg, shift_next;
    logic [SLOT_W-1:0]     rem_reg, rem_next;
    logic [X_W-1:0]        x_reg, x_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [X_W-1:0]        x_cur;
    logic [X_W-1:0]        quot;
    logic [X_W-1:0]        mul_a;
    logic [RECIP_W-1:0]    mul_b;
    logic [PROD_W-1:0]     mul_p;
    logic [SLOT_W:0]       diff;
    logic [SLOT_W:0]       reduced;

    assign x_cur   = {rem_reg, shift_reg[KEY_W-1 -: CHUNK_W]};
    assign quot    = X_W'(prod_reg[PROD_W-1:X_W]);
    assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
    // The true difference stays below twice the divisor, so the low bits suffice.
    assign diff    = x_reg[SLOT_W:0] - prod_reg[SLOT_W:0];
    assign reduced = (diff >= DIV_NARROW) ? (diff - DIV_NARROW) : diff;

    always_comb
    begin
        phase_next     = phase_reg;
        chunk_cnt_next = chunk_cnt_reg;
        done_next      = 1'b0;
        shift_next     = shift_reg;
        rem_next       = rem_reg;
        x_next         = x_reg;
        prod_next      = prod_reg;
        mul_a          = '0;
        mul_b          = '0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    shift_next     = key;
                    rem_next       = '0;
                    chunk_cnt_next = '0;
                    phase_next     = PH_MUL_RECIP;
                end
            end

            PH_MUL_RECIP:
            begin
                mul_a      = x_cur;
                mul_b      = RECIP;
                x_next     = x_cur;
                prod_next  = mul_p;
                shift_next = shift_reg << CHUNK_W;
                phase_next = PH_MUL_DIV;
            end

            PH_MUL_DIV:
            begin
                mul_a      = quot;
                mul_b      = DIVISOR;
                prod_next  = mul_p;
                phase_next = PH_REDUCE;
            end

            PH_REDUCE:
            begin
                rem_next = reduced[SLOT_W-1:0];
                if (chunk_cnt_reg == LAST_CHUNK)
                begin
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    chunk_cnt_next = chunk_cnt_reg + 1'b1;
                    phase_next     = PH_MUL_RECIP;
                end
            end

            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            chunk_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            chunk_cnt_reg <= chunk_cnt_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        x_reg     <= x_next;
        prod_reg  <= prod_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: hw/rtl/kmpt_match.sv
module kmpt_match
    import kmpt_pkg::*;
(
    input  logic [KEY_W-1:0] stored,
    input  logic [KEY_W-1:0] mask,
    input  logic [KEY_W-1:0] prev,
    output match_t           result
);

    assign result.empty   = (stored == '0);
    assign result.equal   = (stored == mask);
    assign result.in_mask = ((stored & mask) == stored);
    assign result.in_prev = ((stored & prev) == stored);

endmodule

FILE: hw/rtl/mask_keyed_probe_table_unit.sv
// channel | direction | handshake        | payload
// in      | to block  | in_valid/in_ready   | mode, component_mask, previous_mask, entity
// out     | from block| out_valid/out_ready | slot, slot_valid, is_new, status,
//         |           |                     | list_action, entity_out, last
// After reset the key memory is cleared, one slot a cycle, with in_ready low throughout.
// Lookup: the home slot is key mod SLOTS, 16 key bits a pass over a shared multiplier,
// and each probe is then a memory read, then a compare.
// Scans: each slot is a memory read, then a compare.
// One item at a time; in_ready is high only between items. A held result in the output
// register stalls the sequencer only when the next result is ready to go.
`include "assert_macros.svh"

module mask_keyed_probe_table_unit
    import kmpt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            mode,
    input  logic [KEY_W-1:0]      component_mask,
    input  logic [KEY_W-1:0]      previous_mask,
    input  logic [ENTITY_W-1:0]   entity,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SLOT_OUT_W-1:0] slot,
    output logic                  slot_valid,
    output logic                  is_new,
    output logic [1:0]            status,
    output logic [1:0]            list_action,
    output logic [ENTITY_W-1:0]   entity_out,
    output logic                  last
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(SLOTS);
    localparam logic [HIT_W-1:0]  HIT_MAX    = HIT_W'(MAX_REPORTS);

    state_t                state_reg, state_next;
    logic [1:0]            mode_reg, mode_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [KEY_W-1:0]      prev_reg, prev_next;
    logic [ENTITY_W-1:0]   entity_reg, entity_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [SLOT_W-1:0]     probe_cnt_reg, probe_cnt_next;
    logic [CNT_W-1:0]      entry_count_reg, entry_count_next;
    logic [HIT_W-1:0]      hit_cnt_reg, hit_cnt_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]     pend_slot_reg, pend_slot_next;
    logic [1:0]            resp_status_reg, resp_status_next;

    logic                  out_valid_reg, out_valid_next;
    logic [SLOT_OUT_W-1:0] slot_reg, slot_next;
    logic                  slot_valid_reg, slot_valid_next;
    logic                  is_new_reg, is_new_next;
    logic [1:0]            status_reg, status_next;
    logic [1:0]            list_action_reg, list_action_next;
    logic [ENTITY_W-1:0]   entity_out_reg, entity_out_next;
    logic                  last_reg, last_next;

    logic                  mem_we;
    logic [KEY_W-1:0]      mem_wdata;
    logic                  mem_re;
    logic [KEY_W-1:0]      mem_rdata;
    logic                  mod_start;
    logic                  mod_done;
    logic [SLOT_W-1:0]     mod_rem;
    match_t                match;

    logic                  out_free;
    logic                  scan_hit;
    logic                  scan_step;
    logic [1:0]            scan_action;
    logic [HIT_W-1:0]      hit_cnt_after;
    logic [SLOT_W+SLOT_OUT_W-1:0] idx_wide;
    logic [SLOT_W+SLOT_OUT_W-1:0] pend_wide;

    kmpt_key_mem #(.SLOTS(SLOTS)) u_key_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (idx_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    kmpt_mod_unit #(.SLOTS(SLOTS)) u_mod_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .key   (key_reg),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    kmpt_match u_match (
        .stored (mem_rdata),
        .mask   (key_reg),
        .prev   (prev_reg),
        .result (match)
    );

    assign out_free    = !out_valid_reg || out_ready;
    assign idx_wide    = {{SLOT_OUT_W{1'b0}}, idx_reg};
    assign pend_wide   = {{SLOT_OUT_W{1'b0}}, pend_slot_reg};
    assign scan_action = (mode_reg == MODE_GAINED) ? ACT_ADD : ACT_REMOVE;
    assign scan_hit    = !match.empty && match.in_mask
                         && !((mode_reg == MODE_GAINED) && match.in_prev);
    assign hit_cnt_after = hit_cnt_reg + HIT_W'(scan_hit);
    // A new hit can retire the pending one only if the output register can take it.
    assign scan_step   = !(scan_hit && pend_valid_reg && !out_free);

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        key_next         = key_reg;
        prev_next        = prev_reg;
        entity_next      = entity_reg;
        idx_next         = idx_reg;
        probe_cnt_next   = probe_cnt_reg;
        entry_count_next = entry_count_reg;
        hit_cnt_next     = hit_cnt_reg;
        pend_valid_next  = pend_valid_reg;
        pend_slot_next   = pend_slot_reg;
        resp_status_next = resp_status_reg;

        out_valid_next   = out_valid_reg && !out_ready;
        slot_next        = slot_reg;
        slot_valid_next  = slot_valid_reg;
        is_new_next      = is_new_reg;
        status_next      = status_reg;
        list_action_next = list_action_reg;
        entity_out_next  = entity_out_reg;
        last_next        = last_reg;

        mem_we    = 1'b0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mod_start = 1'b0;
        in_ready  = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (idx_reg == LAST_SLOT)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next       = mode;
                    key_next        = component_mask;
                    prev_next       = previous_mask;
                    entity_next     = entity;
                    idx_next        = '0;
                    probe_cnt_next  = '0;
                    hit_cnt_next    = '0;
                    pend_valid_next = 1'b0;
                    unique case (mode)
                        MODE_LOOKUP:
                        begin
                            if (component_mask == '0)
                            begin
                                resp_status_next = STATUS_ZERO_KEY;
                                state_next       = ST_RESP;
                            end
                            else if (entry_count_reg == FULL_COUNT)
                            begin
                                resp_status_next = STATUS_FULL;
                                state_next       = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_HASH;
                            end
                        end
                        MODE_GAINED, MODE_REMOVED:
                        begin
                            state_next = ST_SCAN_RD;
                        end
                        default:
                        begin
                            resp_status_next = STATUS_OK;
                            state_next       = ST_RESP;
                        end
                    endcase
                end
            end

            ST_HASH:
            begin
                // Kick the divider on entry; key_reg is loaded by then.
                mod_start = (probe_cnt_reg == '0) && !mod_done && (idx_reg == '0)
                            && (hit_cnt_reg == '0);
                hit_cnt_next = HIT_W'(1);
                if (mod_done)
                begin
                    idx_next     = mod_rem;
                    hit_cnt_next = '0;
                    state_next   = ST_PROBE_RD;
                end
            end

            ST_PROBE_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_PROBE_CHK;
            end

            ST_PROBE_CHK:
            begin
                if (match.empty || match.equal)
                begin
                    if (out_free)
                    begin
                        out_valid_next   = 1'b1;
                        slot_next        = idx_wide[SLOT_OUT_W-1:0];
                        slot_valid_next  = 1'b1;
                        is_new_next      = match.empty;
                        status_next      = STATUS_OK;
                        list_action_next = ACT_NONE;
                        entity_out_next  = '0;
                        last_next        = 1'b1;
                        if (match.empty)
                        begin
                            mem_we           = 1'b1;
                            mem_wdata        = key_reg;
                            entry_count_next = entry_count_reg + 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else if (probe_cnt_reg == LAST_SLOT)
                begin
                    resp_status_next = STATUS_FULL;
                    state_next       = ST_RESP;
                end
                else
                begin
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                    idx_next       = (idx_reg == LAST_SLOT) ? '0 : idx_reg + 1'b1;
                    state_next     = ST_PROBE_RD;
                end
            end

            ST_SCAN_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_SCAN_CHK;
            end

            ST_SCAN_CHK:
            begin
                if (scan_step)
                begin
                    if (scan_hit)
                    begin
                        hit_cnt_next    = hit_cnt_after;
                        pend_valid_next = 1'b1;
                        pend_slot_next  = idx_reg;
                        if (pend_valid_reg)
                        begin
                            out_valid_next   = 1'b1;
                            slot_next        = pend_wide[SLOT_OUT_W-1:0];
                            slot_valid_next  = 1'b1;
                            is_new_next      = 1'b0;
                            status_next      = STATUS_OK;
                            list_action_next = scan_action;
                            entity_out_next  = entity_reg;
                            last_next        = 1'b0;
                        end
                    end
                    if ((idx_reg == LAST_SLOT) || (hit_cnt_after == HIT_MAX))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SCAN_RD;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    is_new_next      = 1'b0;
                    status_next      = STATUS_OK;
                    last_next        = 1'b1;
                    slot_valid_next  = pend_valid_reg;
                    if (pend_valid_reg)
                    begin
                        slot_next        = pend_wide[SLOT_OUT_W-1:0];
                        list_action_next = scan_action;
                        entity_out_next  = entity_reg;
                    end
                    else
                    begin
                        slot_next        = '0;
                        list_action_next = ACT_NONE;
                        entity_out_next  = '0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    slot_next        = '0;
                    slot_valid_next  = 1'b0;
                    is_new_next      = 1'b0;
                    status_next      = resp_status_reg;
                    list_action_next = ACT_NONE;
                    entity_out_next  = '0;
                    last_next        = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            idx_reg         <= '0;
            probe_cnt_reg   <= '0;
            entry_count_reg <= '0;
            hit_cnt_reg     <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            probe_cnt_reg   <= probe_cnt_next;
            entry_count_reg <= entry_count_next;
            hit_cnt_reg     <= hit_cnt_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        key_reg         <= key_next;
        prev_reg        <= prev_next;
        entity_reg      <= entity_next;
        pend_slot_reg   <= pend_slot_next;
        resp_status_reg <= resp_status_next;
        slot_reg        <= slot_next;
        slot_valid_reg  <= slot_valid_next;
        is_new_reg      <= is_new_next;
        status_reg      <= status_next;
        list_action_reg <= list_action_next;
        entity_out_reg  <= entity_out_next;
        last_reg        <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign slot        = slot_reg;
    assign slot_valid  = slot_valid_reg;
    assign is_new      = is_new_reg;
    assign status      = status_reg;
    assign list_action = list_action_reg;
    assign entity_out  = entity_out_reg;
    assign last        = last_reg;

    `ASSERT_HOLDS(a_count_bound, entry_count_reg <= FULL_COUNT, "entry count beyond table size")
    `ASSERT_HOLDS(a_idle_no_pending, (state_reg == ST_IDLE) |-> !pend_valid_reg, "pending report left over")
    `ASSERT_HOLDS(a_report_has_slot, (out_valid_reg && (list_action_reg != ACT_NONE)) |-> (slot_valid_reg && (status_reg == STATUS_OK)), "list report without slot")
    `ASSERT_NEXT(a_insert_counts, (state_reg == ST_PROBE_CHK) && mem_we, entry_count_reg == CNT_W'($past(entry_count_reg) + 1'b1), "insert not counted")

endmodule
